// ----- src/bld_pkg.sv -----
// ----------------------------------------------------------------------------
// bld_pkg
// Shared sizes, request and status codes, and the control state type for the
// bounded list deque with membership search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bld_pkg;

    // Storage geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths of the request and result
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Derived widths
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STORE_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

    // Request codes; anything above ACT_SIZE behaves as a size query
    localparam logic [ACTION_W-1:0] ACT_ADD_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SEARCH    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SIZE      = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } bld_state_t;

endpackage

// ----- src/bounded_list_deque_with_search.sv -----
// ----------------------------------------------------------------------------
// bounded_list_deque_with_search
// Sequence: add, remove and size queries, and a search on an empty list, go
// from acceptance to the finish state and load their result into the output
// register once it is free; a search scans through the single memory read
// port, one stored entry per cycle, and ends early on the first match.
// Throughput: one request at a time; the next is taken in the cycle after the
// result is loaded into the output register, even while that result is stalled.
// Reset: asynchronous, active low; the list comes up empty with front slot 0.
// The entry memory is not reset and is read only at slots that hold entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_list_deque_with_search
    import bld_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    // Request channel
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic        [ACTION_W-1:0] action,
    input  logic signed [VALUE_W-1:0]  value,

    // Result channel
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic                       found,
    output logic        [COUNT_W-1:0]  count,
    output logic                       empty_res,
    output logic        [STATUS_W-1:0] status
);

    // Ring slot of the entry at a given offset from the front
    function automatic logic [IDX_W-1:0] ring_slot(
        input logic [IDX_W-1:0] base,
        input logic [CNT_W-1:0] offset
    );
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Entry memory
    logic [STORE_W-1:0] entry_mem [DEPTH];

    // Control and list state
    bld_state_t          state_reg, state_next;
    logic [ACTION_W-1:0] act_reg;
    logic [STORE_W-1:0]  word_reg;
    logic [IDX_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    scan_idx_reg;
    logic                rd_valid_reg;
    logic                rd_last_reg;
    logic                hit_reg;
    logic [STORE_W-1:0]  rd_data_reg;

    // Output register
    logic                rsp_valid_reg;
    logic                found_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                empty_reg;
    logic [STATUS_W-1:0] status_reg;

    // Sequencer outputs and datapath controls
    logic                accept;
    logic                out_free;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                match;
    logic                finish_en;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic                found_next;
    logic [STATUS_W-1:0] status_next;
    logic                full;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign accept   = req_valid && !req_stall;
    assign match    = rd_valid_reg && (rd_data_reg == word_reg);
    assign full     = (cnt_reg == CNT_W'(DEPTH));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if ((action == ACT_SEARCH) && (cnt_reg != '0))
                        state_next = ST_SCAN;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (match || (rd_valid_reg && rd_last_reg))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req_stall = 1'b1;
        rd_en     = 1'b0;
        finish_en = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            ST_SCAN:
            begin
                rd_en = (scan_idx_reg < cnt_reg);
            end
            ST_FINISH:
            begin
                finish_en = out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign rd_addr = ring_slot(front_reg, scan_idx_reg);

    // Apply the request to the list and form the result
    always_comb
    begin
        front_next  = front_reg;
        cnt_next    = cnt_reg;
        wr_en       = 1'b0;
        wr_addr     = ring_slot(front_reg, cnt_reg);
        found_next  = 1'b0;
        status_next = STAT_DONE;
        case (act_reg)
            ACT_ADD_FRONT:
            begin
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    front_next = (front_reg == '0) ? IDX_W'(DEPTH - 1)
                                                   : front_reg - 1'b1;
                    wr_en      = finish_en;
                    wr_addr    = front_next;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            ACT_ADD_BACK:
            begin
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    wr_en    = finish_en;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ACT_POP_BACK:
            begin
                if (cnt_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                        front_next = '0;
                end
            end
            ACT_SEARCH:
            begin
                found_next = hit_reg;
            end
            default:
            begin
                found_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_en;
            if (finish_en)
            begin
                front_reg     <= front_next;
                cnt_reg       <= cnt_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request latch and scan bookkeeping
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg      <= action;
            word_reg     <= value[STORE_W-1:0];
            scan_idx_reg <= '0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            if (rd_en)
                scan_idx_reg <= scan_idx_reg + 1'b1;
            if ((state_reg == ST_SCAN) && match)
                hit_reg <= 1'b1;
        end
        rd_last_reg <= rd_en && (scan_idx_reg == cnt_reg - 1'b1);
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (finish_en)
        begin
            found_reg  <= found_next;
            count_reg  <= COUNT_W'(cnt_next);
            empty_reg  <= (cnt_next == '0);
            status_reg <= status_next;
        end
    end

    // Memory write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_mem[wr_addr] <= word_reg;
    end

    // Memory read port, registered data
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= entry_mem[rd_addr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign found     = found_reg;
    assign count     = count_reg;
    assign empty_res = empty_reg;
    assign status    = status_reg;

endmodule
